// ----- rtl/core/psieve_pkg.sv -----
// Shared types and constants for the prime sieve table.
package psieve_pkg;

  localparam int LIMIT_W = 16;
  localparam int COUNT_W = 17;
  localparam int NUM_W   = 32;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] RES_NOT_PRIME  = 2'd0;
  localparam logic [1:0] RES_PRIME      = 2'd1;
  localparam logic [1:0] RES_NOT_CACHED = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } psieve_stat_t;

endpackage

// ----- rtl/core/psieve_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module psieve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/psieve_build.sv -----
// Build sequencer: fills, sieves and counts the primality table.
module psieve_build import psieve_pkg::*; #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [LIMIT_W-1:0]            sieve_limit,
  output logic                          wr_en,
  output logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
  output logic                          wr_data,
  output logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  input  logic                          rd_data,
  output psieve_stat_t                  stat,
  output logic [COUNT_W-1:0]            prime_count,
  output logic                          ready_flag,
  output logic [$clog2(TABLE_SIZE)-1:0] built_limit
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int EW = (AW > LIMIT_W) ? AW : LIMIT_W;
  localparam logic [EW-1:0] MAX_LIM = EW'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SCAN_RD, S_SCAN_CHK, S_STRIKE, S_COUNT, S_FINISH
  } state_t;

  state_t           state;
  logic [AW-1:0]    lim;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    i;
  logic [AW:0]      sq;
  logic [AW:0]      k;
  logic [COUNT_W-1:0] cnt;
  logic             pend;
  logic             done;

  logic [EW-1:0]    lim_ext;
  logic [AW-1:0]    lim_sat;
  logic [AW:0]      k_step;
  logic [AW:0]      sq_step;

  assign lim_ext = EW'(sieve_limit);
  assign lim_sat = (lim_ext > MAX_LIM) ? AW'(MAX_LIM) : AW'(lim_ext);
  assign k_step  = k + (AW+1)'(i);
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_step = sq + (AW+1)'({i, 1'b1});

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = 1'b0;
    rd_addr = addr;
    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = (addr >= AW'(2));
      end
      S_STRIKE: begin
        wr_en   = 1'b1;
        wr_addr = k[AW-1:0];
      end
      S_SCAN_RD: rd_addr = i;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      ready_flag  <= 1'b0;
      prime_count <= '0;
      built_limit <= '0;
      pend        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            lim   <= lim_sat;
            addr  <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (addr == lim) begin
            i     <= AW'(2);
            sq    <= (AW+1)'(4);
            state <= S_SCAN_RD;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_SCAN_RD: begin
          if (sq > {1'b0, lim}) begin
            addr  <= '0;
            cnt   <= '0;
            pend  <= 1'b0;
            state <= S_COUNT;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (rd_data) begin
            k     <= sq;
            state <= S_STRIKE;
          end else begin
            i     <= i + AW'(1);
            sq    <= sq_step;
            state <= S_SCAN_RD;
          end
        end
        S_STRIKE: begin
          if (k_step > {1'b0, lim}) begin
            i     <= i + AW'(1);
            sq    <= sq_step;
            state <= S_SCAN_RD;
          end else begin
            k <= k_step;
          end
        end
        S_COUNT: begin
          // the RAM read is registered, so read data belongs to the previous address
          if (pend) begin
            cnt <= cnt + COUNT_W'(rd_data);
          end
          pend <= 1'b1;
          if (addr == lim) begin
            state <= S_FINISH;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_FINISH: begin
          prime_count <= cnt + COUNT_W'(rd_data);
          ready_flag  <= 1'b1;
          built_limit <= lim;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;

endmodule

// ----- rtl/core/prime_sieve_table_top.sv -----
// Top level of the prime sieve table: request decode, query path, table RAM.
//
//  channel   signals                               direction
//  request   start, busy, op, query_number         in (busy out)
//  result    strobe, test_result, prime_total,     out
//            table_ready
//  config    cfg_we, cfg_data (sieve limit)        in
//
// A query's result shows on the cycle after the request, and a new query may
// follow every cycle while no build holds busy (one read of the table RAM).
// A build holds busy while it fills, sieves and counts the table through the
// single RAM write/read port; its result shows in the same cycle that busy
// falls.
// Reset clears the ready flag and count; the table itself is not cleared.
// The receiver cannot stall: each result stands for exactly one cycle.
module prime_sieve_table_top import psieve_pkg::*; #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic signed [NUM_W-1:0]  query_number,
  input  logic                     cfg_we,
  input  logic [LIMIT_W-1:0]       cfg_data,
  output logic                     strobe,
  output logic [1:0]               test_result,
  output logic [COUNT_W-1:0]       prime_total,
  output logic                     table_ready
);

  localparam int AW = $clog2(TABLE_SIZE);

  logic [LIMIT_W-1:0] sieve_limit;
  psieve_stat_t       stat;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               wr_data;
  logic [AW-1:0]      b_rd_addr;
  logic [AW-1:0]      rd_addr;
  logic               rd_data;
  logic [COUNT_W-1:0] prime_count;
  logic               ready_flag;
  logic [AW-1:0]      built_limit;

  logic               accept;
  logic               q_valid;
  logic               q_table;
  logic [1:0]         q_code;
  logic               num_low;
  logic               num_in;

  assign accept = start && !busy;
  assign busy   = stat.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit <= {LIMIT_W{1'b1}};
    end else if (cfg_we) begin
      sieve_limit <= cfg_data;
    end
  end

  psieve_build #(.TABLE_SIZE(TABLE_SIZE)) u_build (
    .clk        (clk),
    .rst        (rst),
    .go         (accept && (op == OP_BUILD)),
    .sieve_limit(sieve_limit),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (b_rd_addr),
    .rd_data    (rd_data),
    .stat       (stat),
    .prime_count(prime_count),
    .ready_flag (ready_flag),
    .built_limit(built_limit)
  );

  // the build owns the read port while busy
  assign rd_addr = stat.busy ? b_rd_addr : query_number[AW-1:0];

  psieve_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign num_low = (query_number <= $signed(NUM_W'(1)));
  assign num_in  = ready_flag && ($unsigned(query_number) <= NUM_W'(built_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= accept && (op == OP_QUERY);
    end
    q_table <= !num_low && num_in;
    q_code  <= num_low ? RES_NOT_PRIME : RES_NOT_CACHED;
  end

  assign strobe      = q_valid || stat.done;
  assign test_result = !q_valid ? RES_NOT_PRIME :
                       q_table  ? (rd_data ? RES_PRIME : RES_NOT_PRIME) : q_code;
  assign prime_total = prime_count;
  assign table_ready = ready_flag;

endmodule

// ----- rtl/core/psieve_chk.sv -----
// Port-level checker for the prime sieve table, bound to the top level.
module psieve_chk import psieve_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       op,
  input logic       strobe,
  input logic [1:0] test_result,
  input logic       table_ready
);

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (test_result != 2'd3))
    else $error("illegal result code");

  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_BUILD) |=> busy)
    else $error("build request did not raise busy");

  a_query_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_QUERY) |=> strobe)
    else $error("query result missing on next cycle");

  a_no_prime_early: assert property (@(posedge clk) disable iff (rst)
    (strobe && !table_ready) |-> (test_result != RES_PRIME))
    else $error("prime answer without a ready table");

  a_build_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |->
      (strobe && table_ready && test_result == RES_NOT_PRIME))
    else $error("build end without its result");

endmodule

bind prime_sieve_table_top psieve_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .op         (op),
  .strobe     (strobe),
  .test_result(test_result),
  .table_ready(table_ready)
);

// ----- test/prime_sieve_table_top_test.sv -----
// Self-checking testbench for the prime sieve table: builds, queries and limit changes.
module prime_sieve_table_top_test;
  import psieve_pkg::*;

  localparam int TABLE_SIZE  = 65536;
  localparam int IDLE_PCT    = 21;
  localparam int MIX_PHASES  = 16;
  localparam int MIX_ITEMS   = 43;
  localparam int DRAIN_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    int unsigned        tag;
    logic               is_build;
    logic [1:0]         verdict;
    logic [COUNT_W-1:0] total;
    logic               ready;
  } sieve_answer_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     op;
  logic signed [NUM_W-1:0]  query_number;
  logic                     cfg_we;
  logic [LIMIT_W-1:0]       cfg_data;
  logic                     strobe;
  logic [1:0]               test_result;
  logic [COUNT_W-1:0]       prime_total;
  logic                     table_ready;

  // Shadow of the block: sieve table, count, ready flag, limits.
  bit                 prime_map [TABLE_SIZE];
  logic [LIMIT_W-1:0] limit_shadow;
  logic [LIMIT_W-1:0] built_limit;
  logic [COUNT_W-1:0] prime_tally;
  logic               table_valid;

  sieve_answer_t pending_answers[$];
  sieve_answer_t want;

  int unsigned request_count;
  int unsigned build_count;
  int unsigned query_count;
  int unsigned limit_writes;
  int unsigned checked_count;
  int unsigned mismatch_count;
  bit          idling_on;

  prime_sieve_table_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .query_number (query_number),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .test_result  (test_result),
    .prime_total  (prime_total),
    .table_ready  (table_ready)
  );

  always #2 clk = ~clk;

  function automatic void rebuild_prime_map();
    int lim;
    int cnt;
    int i;
    int k;
    lim = int'(limit_shadow);
    cnt = 0;
    for (i = 0; i < TABLE_SIZE; i++) prime_map[i] = (i >= 2 && i <= lim);
    for (i = 2; i * i <= lim; i++) begin
      if (prime_map[i]) begin
        for (k = i * i; k <= lim; k += i) prime_map[k] = 1'b0;
      end
    end
    for (i = 0; i <= lim; i++) cnt += prime_map[i];
    prime_tally = COUNT_W'(cnt);
    built_limit = LIMIT_W'(lim);
    table_valid = 1'b1;
  endfunction

  function automatic logic [1:0] classify_number(logic signed [NUM_W-1:0] n);
    int lim;
    lim = int'(built_limit);
    if (n <= 1) return RES_NOT_PRIME;
    if (table_valid && n <= lim)
      return prime_map[n[LIMIT_W-1:0]] ? RES_PRIME : RES_NOT_PRIME;
    return RES_NOT_CACHED;
  endfunction

  // Hold the request until busy is low at an edge, then record its answer.
  task automatic send_request(logic kind, logic signed [NUM_W-1:0] number);
    sieve_answer_t entry;
    start <= 1'b1;
    op <= kind;
    query_number <= number;
    do @(posedge clk); while (busy);
    request_count++;
    entry.tag = request_count;
    entry.is_build = (kind == OP_BUILD);
    if (kind == OP_BUILD) begin
      rebuild_prime_map();
      entry.verdict = RES_NOT_PRIME;
      build_count++;
    end else begin
      entry.verdict = classify_number(number);
      query_count++;
    end
    entry.total = prime_tally;
    entry.ready = table_valid;
    pending_answers.push_back(entry);
    // draw idle cycles at random so about IDLE_PCT of the cycles go idle
    while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start and wait until every answer is in and the block is idle.
  task automatic drain_answers();
    start <= 1'b0;
    do @(negedge clk); while (pending_answers.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    drain_answers();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_shadow = value;
    limit_writes++;
  endtask

  function automatic logic signed [NUM_W-1:0] pick_number();
    int reach;
    reach = (limit_shadow > built_limit) ? int'(limit_shadow) : int'(built_limit);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, reach + 8);
      6: return int'($urandom_range(0, 12)) - 10;
      7, 8: return $urandom;
      default: return int'(built_limit) + int'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  task automatic test_before_build();
    send_request(OP_QUERY, 32'sh8000_0000);
    send_request(OP_QUERY, -1);
    send_request(OP_QUERY, 0);
    send_request(OP_QUERY, 1);
    send_request(OP_QUERY, 2);
    send_request(OP_QUERY, 7);
    send_request(OP_QUERY, 32'sh7FFF_FFFF);
  endtask

  task automatic test_tiny_limits();
    write_limit(2);
    send_request(OP_BUILD, 0);
    send_request(OP_QUERY, 2);
    send_request(OP_QUERY, 3);
    write_limit(1);
    send_request(OP_BUILD, 0);
    send_request(OP_QUERY, 2);
    write_limit(0);
    send_request(OP_BUILD, 0);
    write_limit(3);
    send_request(OP_BUILD, -1);
    send_request(OP_QUERY, 3);
  endtask

  // Raise the limit without a build: queries still see the old table.
  task automatic test_stale_limit();
    write_limit(16'hFFFF);
    send_request(OP_QUERY, 3);
    send_request(OP_QUERY, 5);
  endtask

  task automatic test_full_table();
    send_request(OP_BUILD, 0);
    send_request(OP_QUERY, 65521);
    send_request(OP_QUERY, 65535);
    send_request(OP_QUERY, 65536);
    send_request(OP_QUERY, 32'sh7FFF_FFFF);
    send_request(OP_QUERY, 32'sh8000_0000);
  endtask

  task automatic test_random_mix();
    int p;
    int n;
    int unsigned lim;
    for (p = 0; p < MIX_PHASES; p++) begin
      // phase 0 keeps the full table from the previous test
      if (p > 0) begin
        if (p == 5) lim = 3;
        else if (p % 6 == 0) lim = $urandom_range(1024, 4095);
        else lim = $urandom_range(3, 700);
        write_limit(LIMIT_W'(lim));
      end
      idling_on = !(p >= 8 && p <= 11);
      for (n = 0; n < MIX_ITEMS; n++) begin
        if (p > 0 && $urandom_range(0, 11) == 0) send_request(OP_BUILD, $urandom);
        else send_request(OP_QUERY, pick_number());
        if ($urandom_range(0, 99) == 0) drain_answers();
      end
    end
  endtask

  task automatic finish_run();
    int w;
    start <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && (pending_answers.size() != 0 || busy); w++)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_answers.size() != 0)
      $display("%0d answers never arrived", pending_answers.size());
    $display("Covered %0d builds and %0d queries over %0d limit writes.",
             build_count, query_count, limit_writes);
    $display("%0d results checked, %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result at %0t: verdict %0d total %0d ready %0d",
                   $time, test_result, prime_total, table_ready);
      end else begin
        want = pending_answers.pop_front();
        checked_count++;
        if (test_result !== want.verdict || prime_total !== want.total ||
            table_ready !== want.ready) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("request %0d (%s) at %0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.tag, want.is_build ? "build" : "query", $time,
                     want.verdict, want.total, want.ready,
                     test_result, prime_total, table_ready);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = OP_QUERY;
    query_number = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    limit_shadow = 16'hFFFF;
    built_limit = '0;
    prime_tally = '0;
    table_valid = 1'b0;
    idling_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_build();
    test_tiny_limits();
    test_stale_limit();
    test_full_table();
    test_random_mix();
    finish_run();
  end

endmodule
